// File: rtl/multi_channel_quadrature_counter_unit_defines.svh
// ---------------------------------------------------------------------------
// multi channel quadrature counter unit: assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_QUADRATURE_COUNTER_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_QUADRATURE_COUNTER_UNIT_DEFINES_SVH

// plain property, sampled on every rising edge outside reset
`define MCQC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// antecedent in one cycle, consequent in the next
`define MCQC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

// File: rtl/mcqc_pkg.sv
// ---------------------------------------------------------------------------
// mcqc_pkg
// widths, transition codes and the 4x decode table of the quadrature counter
// ---------------------------------------------------------------------------
package mcqc_pkg;

	localparam int FIELD_CHANNELS = 4;
	localparam int PAIR_W         = 2;
	localparam int PINS_W         = FIELD_CHANNELS * PAIR_W;
	localparam int COUNT_W        = 32;
	localparam int RESULT_W       = FIELD_CHANNELS * COUNT_W;

	// transition code is {previous pair, current pair}
	localparam logic [3:0] FWD_00_01 = 4'b0001;
	localparam logic [3:0] FWD_01_11 = 4'b0111;
	localparam logic [3:0] FWD_11_10 = 4'b1110;
	localparam logic [3:0] FWD_10_00 = 4'b1000;
	localparam logic [3:0] BWD_00_10 = 4'b0010;
	localparam logic [3:0] BWD_10_11 = 4'b1011;
	localparam logic [3:0] BWD_11_01 = 4'b1101;
	localparam logic [3:0] BWD_01_00 = 4'b0100;

	typedef enum logic [1:0] {
		DELTA_NONE,
		DELTA_UP,
		DELTA_DOWN
	} delta_t;

	function automatic delta_t quad_delta(input logic [3:0] code);
		delta_t d;
		case (code) inside
			FWD_00_01, FWD_01_11, FWD_11_10, FWD_10_00: d = DELTA_UP;
			BWD_00_10, BWD_10_11, BWD_11_01, BWD_01_00: d = DELTA_DOWN;
			default:                                    d = DELTA_NONE;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/multi_channel_quadrature_counter_unit.sv
// ---------------------------------------------------------------------------
// multi_channel_quadrature_counter_unit
// 4x quadrature decoder for up to four a/b encoder channels with 32-bit counts
// ---------------------------------------------------------------------------
//
//  channel | dir | tdata (lowest bit up)                  | tuser / tlast
//  --------+-----+----------------------------------------+--------------
//  s_axis  | in  | pins[7:0]                              | none
//  m_axis  | out | count_0, count_1, count_2, count_3     | none
//
// one item per clock sustained while m_axis does not stall; an item passes from
// s_axis to m_axis through the input register and then the result register
// the count update is one 32-bit increment/decrement per channel between the
// input register and the count registers, which double as the result payload
// arst_n clears counts, previous pins, the primed flag and both valid bits
// a stalled m_axis holds the result; s_axis keeps taking items as long as the
// input register can move on, so at most two items are in flight
//
module multi_channel_quadrature_counter_unit #(
	parameter int CHANNELS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [mcqc_pkg::PINS_W-1:0]    s_axis_tdata,   // pins
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [mcqc_pkg::RESULT_W-1:0]  m_axis_tdata    // count_0, count_1, count_2, count_3
);

	import mcqc_pkg::*;

	// only four pairs fit the pin sample, more channels act as four
	localparam int ACTIVE = (CHANNELS > FIELD_CHANNELS) ? FIELD_CHANNELS : CHANNELS;

	// input register
	logic              valid_s1;
	logic [PINS_W-1:0] pins_s1;

	// decoder state
	logic [PINS_W-1:0] prev_pins_q;
	logic              primed_q;
	logic              out_valid_q;

	// the input register hands its item to the result side
	logic move;

	assign move          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || move;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pins_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev_pins_q <= '0;
			primed_q    <= 1'b0;
		end else begin
			if (move) begin
				out_valid_q <= 1'b1;
				prev_pins_q <= pins_s1;
				primed_q    <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per channel decode and count; counts only change when a result is
	// loaded, so they are the result payload as well
	for (genvar c = 0; c < FIELD_CHANNELS; c++) begin : g_ch
		if (c < ACTIVE) begin : g_active
			logic [COUNT_W-1:0] count_q;
			delta_t             delta;

			// first sample after reset only records the pins
			assign delta = primed_q ? quad_delta({prev_pins_q[c*PAIR_W +: PAIR_W],
			                                      pins_s1[c*PAIR_W +: PAIR_W]})
			                        : DELTA_NONE;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					count_q <= '0;
				end else if (move) begin
					case (delta)
						DELTA_UP:   count_q <= count_q + COUNT_W'(1);
						DELTA_DOWN: count_q <= count_q - COUNT_W'(1);
						default:    count_q <= count_q;
					endcase
				end
			end

			assign m_axis_tdata[c*COUNT_W +: COUNT_W] = count_q;
		end else begin : g_idle
			// channel not fitted, its field stays zero
			assign m_axis_tdata[c*COUNT_W +: COUNT_W] = '0;
		end
	end

endmodule

// File: rtl/mcqc_checker.sv
// ---------------------------------------------------------------------------
// mcqc_checker
// port level checks of the quadrature counter unit, bound to the top level
// ---------------------------------------------------------------------------
`include "multi_channel_quadrature_counter_unit_defines.svh"

module mcqc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [mcqc_pkg::RESULT_W-1:0]  m_axis_tdata
);

	logic s_take;
	logic m_stall;

	assign s_take  = s_axis_tvalid && s_axis_tready;
	assign m_stall = m_axis_tvalid && !m_axis_tready;

	// stalled result holds
	`MCQC_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// with no result waiting the input side must be open
	`MCQC_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")

	// every accepted item must be followed by a valid result
	`MCQC_ASSERT(a_latency, s_take |-> ##2 m_axis_tvalid, "accepted item produced no result")

endmodule

bind multi_channel_quadrature_counter_unit mcqc_checker u_mcqc_checker (.*);

// File: tb/multi_channel_quadrature_counter_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_channel_quadrature_counter_unit_tb
// drives pin samples into the 4x quadrature counter and checks every count
// item against a local decoder model. Stimulus opens with a directed list:
// first sample after reset, no change, every forward and backward step,
// three of the four illegal jumps, and a wrap below zero. It then goes on
// to encoder-like random walks with illegal jumps and noise mixed in. Both
// stream sides idle and stall at random across four phases.
// ---------------------------------------------------------------------------
module multi_channel_quadrature_counter_unit_tb;

	import mcqc_pkg::*;

	localparam int CHANNELS     = 4;
	localparam int WATCHDOG_MAX = 2000;
	localparam int PHASE_ITEMS  = 175;
	localparam int DRAIN_CYCLES = 10;

	// next pair when an encoder moves one step, indexed by the current pair {b, a}
	localparam logic [1:0] FWD_NEXT [4] = '{2'b01, 2'b11, 2'b00, 2'b10};
	localparam logic [1:0] BWD_NEXT [4] = '{2'b10, 2'b00, 2'b11, 2'b01};

	// hand-picked opening samples, all four channels move together unless noted
	localparam int DIRECTED_N = 17;
	localparam logic [PINS_W-1:0] DIRECTED [DIRECTED_N] = '{
		8'hFF,  // first sample after reset, only recorded
		8'hFF,  // no change
		8'h00,  // illegal jump 11 -> 00
		8'h55,  // forward 00 -> 01
		8'hFF,  // forward 01 -> 11
		8'hAA,  // forward 11 -> 10
		8'h00,  // forward 10 -> 00
		8'hAA,  // backward 00 -> 10
		8'hFF,  // backward 10 -> 11
		8'h55,  // backward 11 -> 01
		8'h00,  // backward 01 -> 00, counts back at zero
		8'hAA,  // backward once more, counts wrap to all ones
		8'h55,  // illegal jump 10 -> 01
		8'hAA,  // illegal jump 01 -> 10
		8'hFF,  // backward 10 -> 11
		8'h6C,  // mixed: ch0 illegal, ch1 hold, ch2 fwd, ch3 bwd
		8'h00   // mixed again, all bits low
	};

	// one packed entry per channel, channel 0 in the lowest bits like tdata
	typedef logic [FIELD_CHANNELS-1:0][COUNT_W-1:0] count_set_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [PINS_W-1:0]    s_axis_tdata  = '0;   // pins
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [RESULT_W-1:0]  m_axis_tdata;         // count_0, count_1, count_2, count_3

	// samples waiting for the driver, and count sets waiting for the dut
	logic [PINS_W-1:0] pins_to_send [$];
	count_set_t        expected_counts [$];

	// decoder model state
	logic [PINS_W-1:0]  last_pins;
	logic [COUNT_W-1:0] running_counts [FIELD_CHANNELS];
	logic               seen_sample;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int quiet_cycles   = 0;

	multi_channel_quadrature_counter_unit #(
		.CHANNELS(CHANNELS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// +1 for a forward step, -1 for a backward step, 0 for hold or illegal jump
	function automatic int transition_step(input logic [3:0] code);
		int step;
		case (code)
			FWD_00_01, FWD_01_11, FWD_11_10, FWD_10_00: step = 1;
			BWD_00_10, BWD_10_11, BWD_11_01, BWD_01_00: step = -1;
			default:                                    step = 0;
		endcase
		return step;
	endfunction

	// advance the decoder model by one accepted sample and queue the counts it shows
	task automatic track_sample(input logic [PINS_W-1:0] sample);
		count_set_t shown;
		int         step;
		if (seen_sample) begin
			for (int c = 0; c < FIELD_CHANNELS && c < CHANNELS; c++) begin
				step = transition_step({last_pins[2*c +: 2], sample[2*c +: 2]});
				if (step > 0)
					running_counts[c] = running_counts[c] + 32'd1;
				else if (step < 0)
					running_counts[c] = running_counts[c] - 32'd1;
			end
		end
		last_pins   = sample;
		seen_sample = 1'b1;
		// channels at or above CHANNELS read as zero
		for (int c = 0; c < FIELD_CHANNELS; c++)
			shown[c] = (c < CHANNELS) ? running_counts[c] : '0;
		expected_counts.push_back(shown);
	endtask

	// driver: presents the next pending sample, holding it until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				track_sample(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pins_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pins_to_send.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: takes count items at random and checks every channel field
	always @(posedge clk or negedge arst_n) begin : count_monitor
		count_set_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_counts.size() == 0) begin
					error_count++;
					$display("%0t: count item with nothing expected, actual %h",
						$time, m_axis_tdata);
				end else begin
					want = expected_counts.pop_front();
					for (int c = 0; c < FIELD_CHANNELS; c++) begin
						if (m_axis_tdata[c*COUNT_W +: COUNT_W] !== want[c]) begin
							error_count++;
							$display("%0t: count_%0d mismatch, expected %0d actual %0d",
								$time, c, $signed(want[c]),
								$signed(m_axis_tdata[c*COUNT_W +: COUNT_W]));
						end
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: too long without any handshake on either side ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// stimulus: reset, directed samples, then random walks over four idling phases
	initial begin : stimulus
		logic [PINS_W-1:0] walk_pins;
		logic [1:0]        pair;
		bit                walk_up [FIELD_CHANNELS];
		int                kind;
		int                roll;
		int                ch;

		last_pins   = '0;
		seen_sample = 1'b0;
		for (int c = 0; c < FIELD_CHANNELS; c++) begin
			running_counts[c] = '0;
			walk_up[c]        = 1'($urandom_range(1));
		end

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_N; i++)
			pins_to_send.push_back(DIRECTED[i]);
		walk_pins = DIRECTED[DIRECTED_N-1];

		for (int phase = 0; phase < 4; phase++) begin
			// no idling, sender idle, receiver stalling, both
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				kind = $urandom_range(99);
				if (kind < 80) begin
					// encoder walk: each channel mostly steps in its current direction
					for (int c = 0; c < FIELD_CHANNELS; c++) begin
						if ($urandom_range(9) == 0)
							walk_up[c] = !walk_up[c];
						pair = walk_pins[2*c +: 2];
						roll = $urandom_range(9);
						if (roll < 7)
							pair = walk_up[c] ? FWD_NEXT[pair] : BWD_NEXT[pair];
						else if (roll == 7)
							pair = walk_up[c] ? BWD_NEXT[pair] : FWD_NEXT[pair];
						walk_pins[2*c +: 2] = pair;
					end
				end else if (kind < 90) begin
					// illegal jump on one channel
					ch = $urandom_range(FIELD_CHANNELS-1);
					walk_pins[2*ch +: 2] = ~walk_pins[2*ch +: 2];
				end else begin
					// noise
					walk_pins = PINS_W'($urandom);
				end
				pins_to_send.push_back(walk_pins);
			end
			while (pins_to_send.size() != 0 || s_axis_tvalid || expected_counts.size() != 0)
				@(negedge clk);
		end

		// two-stage pipeline, give any stray item time to show up
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0 && expected_counts.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/mcqc_pkg.sv
rtl/multi_channel_quadrature_counter_unit.sv
rtl/mcqc_checker.sv
tb/multi_channel_quadrature_counter_unit_tb.sv
